[hw/rtl/ata_pio_command_sequencer_unit_defines.svh]
// Assertion macros for the ATA PIO command sequencer.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef ATA_PIO_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define ATA_PIO_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/apcs_pkg.sv]
// Shared types, constants and helpers for the ATA PIO command sequencer.
// No dependencies; used by apcs_core, apcs_emit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package apcs_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int IDENT_WORDS      = 256;
  localparam int WCNT_W           = $clog2(WORDS_PER_SECTOR + 1);
  localparam int MAX_RES          = 6;
  localparam int RES_CNT_W        = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W        = $clog2(MAX_RES);

  // Request modes.
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_STATUS = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;

  // Operations on a start request.
  localparam logic [1:0] OP_IDENT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // Completion codes.
  localparam logic [1:0] RC_OK     = 2'd0;
  localparam logic [1:0] RC_NODEV  = 2'd1;
  localparam logic [1:0] RC_DEVERR = 2'd2;
  localparam logic [1:0] RC_REJECT = 2'd3;

  // Task-file register offsets.
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_DEVHEAD = 3'd6;
  localparam logic [2:0] REG_CMD     = 3'd7;

  // Command bytes and fixed register values.
  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h30;
  localparam logic [7:0] CMD_FLUSH    = 8'hE7;
  localparam logic [7:0] DEVHEAD_BASE = 8'hE0;
  localparam logic [7:0] STS_FLOAT    = 8'hFF;
  localparam logic [7:0] STS_NONE     = 8'h00;

  // Status bit positions.
  localparam int STS_BSY = 7;
  localparam int STS_DRQ = 3;
  localparam int STS_ERR = 0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  operation;
    logic        channel;
    logic        drive_select;
    logic [27:0] block_address;
    logic [7:0]  sector_total;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
  } in_t;

  typedef struct packed {
    logic        bus_write;
    logic        channel_out;
    logic [2:0]  reg_offset;
    logic [15:0] bus_value;
    logic        word_valid;
    logic [15:0] word_out;
    logic        done_res;
    logic [1:0]  result_code;
    logic        last;
  } out_t;

  // All results caused by one request; last is filled in by the emitter.
  typedef struct packed {
    logic [RES_CNT_W-1:0]    cnt;
    out_t [MAX_RES-1:0]      res;
  } bundle_t;

  function automatic out_t mk_res(logic bw, logic ch, logic [2:0] rg, logic [15:0] val,
                                  logic wv, logic [15:0] wo, logic dn, logic [1:0] rc);
    out_t r;
    r.bus_write   = bw;
    r.channel_out = ch;
    r.reg_offset  = rg;
    r.bus_value   = val;
    r.word_valid  = wv;
    r.word_out    = wo;
    r.done_res    = dn;
    r.result_code = rc;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/apcs_core.sv]
// Protocol state and per-request decode of the ATA PIO command sequencer.
// Depends on apcs_pkg; the state commits only when the top level takes a request.
`timescale 1ns / 1ps
`default_nettype none

module apcs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  apcs_pkg::in_t     item,
  output apcs_pkg::bundle_t bnd
);

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_DATA, PH_FLUSH} phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [1:0]                    op_r, op_nxt;
  logic                          ch_r, ch_nxt;
  logic                          first_r, first_nxt;
  logic [7:0]                    sect_r, sect_nxt;
  logic [apcs_pkg::WCNT_W-1:0]   words_r, words_nxt;
  logic                          flush_r, flush_nxt;

  logic                          bsy, drq, err;
  logic                          ident;
  logic [7:0]                    devhead;
  logic [7:0]                    cmd;
  logic [15:0]                   cnt_val, lo_val, mid_val, hi_val;

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    ch_nxt    = ch_r;
    first_nxt = first_r;
    sect_nxt  = sect_r;
    words_nxt = words_r;
    flush_nxt = flush_r;
    bnd       = '0;

    bsy   = item.status_byte[apcs_pkg::STS_BSY];
    drq   = item.status_byte[apcs_pkg::STS_DRQ];
    err   = item.status_byte[apcs_pkg::STS_ERR];
    ident = (item.operation == apcs_pkg::OP_IDENT);

    // Identify addresses nothing, so count and LBA registers are written with zero.
    devhead = apcs_pkg::DEVHEAD_BASE | {3'b000, item.drive_select, 4'b0000}
              | (ident ? 8'h00 : {4'b0000, item.block_address[27:24]});
    cnt_val = ident ? 16'h0000 : {8'h00, item.sector_total};
    lo_val  = ident ? 16'h0000 : {8'h00, item.block_address[7:0]};
    mid_val = ident ? 16'h0000 : {8'h00, item.block_address[15:8]};
    hi_val  = ident ? 16'h0000 : {8'h00, item.block_address[23:16]};
    cmd     = ident ? apcs_pkg::CMD_IDENTIFY
            : ((item.operation == apcs_pkg::OP_READ) ? apcs_pkg::CMD_READ
                                                     : apcs_pkg::CMD_WRITE);

    case (item.mode)
      apcs_pkg::MODE_START: begin
        if (phase_r != PH_IDLE || item.operation == apcs_pkg::OP_RSVD ||
            (!ident && item.sector_total == 8'd0)) begin
          bnd.cnt    = apcs_pkg::RES_CNT_W'(1);
          bnd.res[0] = apcs_pkg::mk_res(1'b0, item.channel, apcs_pkg::REG_DATA, 16'h0000,
                                        1'b0, 16'h0000, 1'b1, apcs_pkg::RC_REJECT);
        end else begin
          op_nxt     = item.operation;
          ch_nxt     = item.channel;
          flush_nxt  = 1'b0;
          phase_nxt  = PH_WAIT;
          first_nxt  = ident;
          sect_nxt   = ident ? 8'd1 : item.sector_total;
          bnd.cnt    = apcs_pkg::RES_CNT_W'(apcs_pkg::MAX_RES);
          bnd.res[0] = apcs_pkg::mk_res(1'b1, item.channel, apcs_pkg::REG_DEVHEAD,
                                        {8'h00, devhead}, 1'b0, 16'h0000, 1'b0,
                                        apcs_pkg::RC_OK);
          bnd.res[1] = apcs_pkg::mk_res(1'b1, item.channel, apcs_pkg::REG_COUNT, cnt_val,
                                        1'b0, 16'h0000, 1'b0, apcs_pkg::RC_OK);
          bnd.res[2] = apcs_pkg::mk_res(1'b1, item.channel, apcs_pkg::REG_LBA_LO, lo_val,
                                        1'b0, 16'h0000, 1'b0, apcs_pkg::RC_OK);
          bnd.res[3] = apcs_pkg::mk_res(1'b1, item.channel, apcs_pkg::REG_LBA_MID, mid_val,
                                        1'b0, 16'h0000, 1'b0, apcs_pkg::RC_OK);
          bnd.res[4] = apcs_pkg::mk_res(1'b1, item.channel, apcs_pkg::REG_LBA_HI, hi_val,
                                        1'b0, 16'h0000, 1'b0, apcs_pkg::RC_OK);
          bnd.res[5] = apcs_pkg::mk_res(1'b1, item.channel, apcs_pkg::REG_CMD,
                                        {8'h00, cmd}, 1'b0, 16'h0000, 1'b0,
                                        apcs_pkg::RC_OK);
        end
      end

      apcs_pkg::MODE_STATUS: begin
        if (phase_r == PH_WAIT) begin
          if (op_r == apcs_pkg::OP_IDENT) begin
            if (first_r) begin
              // The first sample after IDENTIFY only probes for a floating bus.
              first_nxt = 1'b0;
              if (item.status_byte == apcs_pkg::STS_NONE ||
                  item.status_byte == apcs_pkg::STS_FLOAT) begin
                bnd.cnt    = apcs_pkg::RES_CNT_W'(1);
                bnd.res[0] = apcs_pkg::mk_res(1'b0, ch_r, apcs_pkg::REG_DATA, 16'h0000,
                                              1'b0, 16'h0000, 1'b1, apcs_pkg::RC_NODEV);
                phase_nxt  = PH_IDLE;
                flush_nxt  = 1'b0;
              end
            end else if (!bsy) begin
              if (drq) begin
                phase_nxt = PH_DATA;
                words_nxt = apcs_pkg::WCNT_W'(apcs_pkg::IDENT_WORDS);
              end else if (err) begin
                bnd.cnt    = apcs_pkg::RES_CNT_W'(1);
                bnd.res[0] = apcs_pkg::mk_res(1'b0, ch_r, apcs_pkg::REG_DATA, 16'h0000,
                                              1'b0, 16'h0000, 1'b1, apcs_pkg::RC_DEVERR);
                phase_nxt  = PH_IDLE;
                first_nxt  = 1'b0;
                flush_nxt  = 1'b0;
              end
            end
          end else if (!bsy && drq) begin
            phase_nxt = PH_DATA;
            words_nxt = apcs_pkg::WCNT_W'(apcs_pkg::WORDS_PER_SECTOR);
          end
        end else if (phase_r == PH_FLUSH && !bsy) begin
          bnd.cnt = apcs_pkg::RES_CNT_W'(1);
          if (!flush_r) begin
            flush_nxt  = 1'b1;
            bnd.res[0] = apcs_pkg::mk_res(1'b1, ch_r, apcs_pkg::REG_CMD,
                                          {8'h00, apcs_pkg::CMD_FLUSH}, 1'b0, 16'h0000,
                                          1'b0, apcs_pkg::RC_OK);
          end else begin
            bnd.res[0] = apcs_pkg::mk_res(1'b0, ch_r, apcs_pkg::REG_DATA, 16'h0000,
                                          1'b0, 16'h0000, 1'b1, apcs_pkg::RC_OK);
            phase_nxt  = PH_IDLE;
            first_nxt  = 1'b0;
            flush_nxt  = 1'b0;
          end
        end
      end

      apcs_pkg::MODE_DATA: begin
        if (phase_r == PH_DATA) begin
          bnd.cnt = apcs_pkg::RES_CNT_W'(1);
          if (op_r == apcs_pkg::OP_WRITE) begin
            bnd.res[0] = apcs_pkg::mk_res(1'b1, ch_r, apcs_pkg::REG_DATA, item.data_word,
                                          1'b0, 16'h0000, 1'b0, apcs_pkg::RC_OK);
          end else begin
            bnd.res[0] = apcs_pkg::mk_res(1'b0, ch_r, apcs_pkg::REG_DATA, 16'h0000,
                                          1'b1, item.data_word, 1'b0, apcs_pkg::RC_OK);
          end
          if (words_r != '0) begin
            words_nxt = words_r - apcs_pkg::WCNT_W'(1);
          end
          if (words_nxt == '0) begin
            if (sect_r != 8'd0) begin
              sect_nxt = sect_r - 8'd1;
            end
            if (sect_nxt != 8'd0) begin
              phase_nxt = PH_WAIT;
            end else if (op_r == apcs_pkg::OP_WRITE) begin
              phase_nxt = PH_FLUSH;
              flush_nxt = 1'b0;
            end else begin
              bnd.cnt    = apcs_pkg::RES_CNT_W'(2);
              bnd.res[1] = apcs_pkg::mk_res(1'b0, ch_r, apcs_pkg::REG_DATA, 16'h0000,
                                            1'b0, 16'h0000, 1'b1, apcs_pkg::RC_OK);
              phase_nxt  = PH_IDLE;
            end
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= apcs_pkg::OP_IDENT;
      ch_r    <= 1'b0;
      first_r <= 1'b0;
      sect_r  <= 8'd0;
      words_r <= '0;
      flush_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      ch_r    <= ch_nxt;
      first_r <= first_nxt;
      sect_r  <= sect_nxt;
      words_r <= words_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/apcs_emit.sv]
// Result register of the ATA PIO command sequencer: holds the results of one
// request and hands them out one per cycle while out_stall is low. Depends on apcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apcs_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  apcs_pkg::bundle_t bnd,
  input  logic              out_stall,
  output logic              out_valid,
  output apcs_pkg::out_t    out_data,
  output logic              free
);

  logic                              vld_r, vld_nxt;
  logic [apcs_pkg::RES_IDX_W-1:0]    idx_r, idx_nxt;
  logic [apcs_pkg::RES_CNT_W-1:0]    cnt_r, cnt_nxt;
  apcs_pkg::out_t [apcs_pkg::MAX_RES-1:0] res_r, res_nxt;
  logic                              pop;
  logic                              is_last;

  assign pop     = vld_r && !out_stall;
  assign is_last = (apcs_pkg::RES_CNT_W'(idx_r) == cnt_r - apcs_pkg::RES_CNT_W'(1));
  // The slot frees up in the same cycle its final result leaves.
  assign free    = !vld_r || (pop && is_last);

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    if (pop && !is_last) begin
      idx_nxt = idx_r + apcs_pkg::RES_IDX_W'(1);
    end else if (pop) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = '0;
      cnt_nxt = bnd.cnt;
      res_nxt = bnd.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    out_data      = res_r[idx_r];
    out_data.last = is_last;
  end

  assign out_valid = vld_r;

endmodule

`default_nettype wire

[hw/rtl/ata_pio_command_sequencer_unit.sv]
// A request is held in the input register and its results are registered in the result
// register. Throughput: one request per cycle when each gives at most one result and
// out_stall is low; a start yields six results and a read's final data word two.
// The output result register is the only thing that limits the rate.
// Reset (rst_n low, synchronous) idles the sequencer and drops any held request or result.
`timescale 1ns / 1ps
`default_nettype none
`include "ata_pio_command_sequencer_unit_defines.svh"

module ata_pio_command_sequencer_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  apcs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output apcs_pkg::out_t out_data
);

  logic              in_vld_r;
  apcs_pkg::in_t     in_q_r;
  logic              take;
  logic              emit_free;
  apcs_pkg::bundle_t bnd;

  // A request that yields no result never waits for the result register.
  assign take     = in_vld_r && (emit_free || bnd.cnt == '0);
  assign in_stall = in_vld_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_vld_r || take) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_q_r <= in_data;
    end
  end

  apcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_q_r),
    .bnd   (bnd)
  );

  apcs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && bnd.cnt != '0),
    .bnd       (bnd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (emit_free)
  );

  `APCS_ASSERT_NXT(a_in_hold, in_vld_r && !take, in_vld_r && $stable(in_q_r), "held request changed")
  `APCS_ASSERT_IMP(a_done_last, out_valid && out_data.done_res, out_data.last, "done result not last")
  `APCS_ASSERT_IMP(a_code_done, out_valid && !out_data.done_res, out_data.result_code == apcs_pkg::RC_OK, "code without done")
  `APCS_ASSERT_IMP(a_write_word, out_valid && out_data.bus_write, !out_data.word_valid, "write and word together")

endmodule

`default_nettype wire
